### hw/rtl/decimal96_to_ascii_top_defines.svh
// -----------------------------------------------------------------------------
// decimal96_to_ascii_top_defines: assertion macros
// Assertion helpers clocked on clk, disabled while arst_n is low.
// Under synthesis the macros expand to nothing.
// -----------------------------------------------------------------------------
`ifndef DECIMAL96_TO_ASCII_TOP_DEFINES_SVH
`define DECIMAL96_TO_ASCII_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every edge
`define D2A_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("d2a assertion failed");

// antecedent implies consequent on the following edge
`define D2A_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("d2a assertion failed");

// antecedent implies consequent on the same edge
`define D2A_ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("d2a assertion failed");

`else

`define D2A_ASSERT(lbl, cond)
`define D2A_ASSERT_NEXT(lbl, pre, post)
`define D2A_ASSERT_SAME(lbl, pre, post)

`endif

`endif

### hw/rtl/d2a_pkg.sv
// -----------------------------------------------------------------------------
// d2a_pkg: shared types and constants
// Beat payloads, ASCII codes and digit cell modes for the decimal printer.
// -----------------------------------------------------------------------------
`default_nettype none

package d2a_pkg;

	localparam int MANTISSA_BITS_DEF = 96;
	localparam int MAX_DIGITS_DEF    = 29;
	localparam int DIGIT_W           = 4;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [7:0] ASCII_DOT   = 8'h2E;

	typedef logic [1:0] cell_mode_t;

	localparam cell_mode_t CELL_HOLD   = 2'd0;
	localparam cell_mode_t CELL_CLEAR  = 2'd1;
	localparam cell_mode_t CELL_DABBLE = 2'd2;
	localparam cell_mode_t CELL_SHIFT  = 2'd3;

	typedef logic [DIGIT_W-1:0] digit_t;

	typedef struct packed {
		logic [63:0] mantissa_low;
		logic [31:0] mantissa_high;
		logic [4:0]  scale;
		logic        negative;
	} in_item_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       last_char;
	} out_item_t;

endpackage

`default_nettype wire

### hw/rtl/d2a_if.sv
// -----------------------------------------------------------------------------
// d2a_if: valid/ready stream channel
// One beat moves when valid and ready are both high at a rising edge.
// -----------------------------------------------------------------------------
`default_nettype none

interface d2a_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hw/rtl/d2a_cell.sv
// -----------------------------------------------------------------------------
// d2a_cell: one decimal digit cell
// Holds a bcd digit; clears it, adds 3 when five or more and shifts in a bit, or takes its neighbor's digit.
// -----------------------------------------------------------------------------
`default_nettype none

module d2a_cell (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire d2a_pkg::cell_mode_t mode,
	input  wire                      bit_in,
	input  wire d2a_pkg::digit_t     digit_in,
	output d2a_pkg::digit_t          digit,
	output logic                     bit_out
);
	import d2a_pkg::*;

	digit_t digit_q;
	digit_t adj;

	// add 3 when five or more so the doubled digit carries at ten
	assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign bit_out = adj[DIGIT_W-1];
	assign digit   = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else begin
			unique case (mode)
				CELL_CLEAR:  digit_q <= '0;
				CELL_DABBLE: digit_q <= {adj[DIGIT_W-2:0], bit_in};
				CELL_SHIFT:  digit_q <= digit_in;
				default:     digit_q <= digit_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/d2a_chain.sv
// -----------------------------------------------------------------------------
// d2a_chain: row of digit cells
// Cell 0 is the least significant digit; the mantissa enters there bit by bit
// and digits leave at the top during printing.
// -----------------------------------------------------------------------------
`default_nettype none

module d2a_chain #(
	parameter int MAX_DIGITS = d2a_pkg::MAX_DIGITS_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire d2a_pkg::cell_mode_t mode,
	input  wire                      bit_in,
	output d2a_pkg::digit_t          top_digit
);
	import d2a_pkg::*;

	digit_t digits [MAX_DIGITS];
	logic   carry  [MAX_DIGITS];

	for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
		if (k == 0) begin : g_first
			d2a_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.mode     (mode),
				.bit_in   (bit_in),
				.digit_in ('0),
				.digit    (digits[k]),
				.bit_out  (carry[k])
			);
		end else begin : g_next
			d2a_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.mode     (mode),
				.bit_in   (carry[k-1]),
				.digit_in (digits[k-1]),
				.digit    (digits[k]),
				.bit_out  (carry[k])
			);
		end
	end

	assign top_digit = digits[MAX_DIGITS-1];

endmodule

`default_nettype wire

### hw/rtl/decimal96_to_ascii_top.sv
// -----------------------------------------------------------------------------
// decimal96_to_ascii_top: 96-bit decimal to ASCII text
// Converts mantissa, scale and sign into a string of ASCII characters.
// -----------------------------------------------------------------------------
// Takes one decimal number per beat on number (96-bit unsigned mantissa split
// into low and high words, a scale of 0..28 fraction digits, a sign flag) and
// sends its text on text, one character per beat, most significant first:
// an optional '-', the integer digits without leading zeros (a single '0'
// when the integer part is empty), then '.' and exactly scale fraction digits
// when scale is above zero. last_char marks the final character. Scales
// above MAX_DIGITS-1 are clamped to it. A number occupies the block for a
// double dabble pass, in which the mantissa is shifted into a row of
// MAX_DIGITS bcd digit cells one bit per cycle, and then for printing, in
// which that row shifts up one digit per cycle while text is not held off
// by ready; each shift either sends the top digit or drops it as a leading
// zero. A '-' and a '.' are each sent from a sequencer state of their own.
// number.ready is high only between numbers.
// -----------------------------------------------------------------------------
`default_nettype none

`include "decimal96_to_ascii_top_defines.svh"

module decimal96_to_ascii_top #(
	parameter int MANTISSA_BITS = d2a_pkg::MANTISSA_BITS_DEF,
	parameter int MAX_DIGITS    = d2a_pkg::MAX_DIGITS_DEF
) (
	input  wire    clk,
	input  wire    arst_n,
	d2a_if.sink    number,
	d2a_if.source  text
);
	import d2a_pkg::*;

	localparam int CNT_W = $clog2(MANTISSA_BITS + 1);
	localparam int POS_W = $clog2(MAX_DIGITS + 1);

	localparam logic [CNT_W-1:0] LAST_SHIFT = CNT_W'(MANTISSA_BITS - 1);
	localparam logic [POS_W-1:0] POS_TOP    = POS_W'(MAX_DIGITS);
	localparam logic [POS_W-1:0] POS_ONE    = POS_W'(1);
	localparam logic [4:0]       SCALE_MAX  = 5'(MAX_DIGITS - 1);

	// sequencer codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CONV  = 3'd1;
	localparam logic [2:0] ST_SIGN  = 3'd2;
	localparam logic [2:0] ST_DIGIT = 3'd3;
	localparam logic [2:0] ST_DOT   = 3'd4;

	logic [2:0]               state_q, state_d;
	logic [CNT_W-1:0]         cnt_q;        // dabble shifts done
	logic [POS_W-1:0]         pos_q;        // digit position at the top cell, 1-based
	logic                     started_q;    // a digit has been sent already
	logic                     neg_q;
	logic [4:0]               scale_q;
	logic [MANTISSA_BITS-1:0] mant_q;
	logic                     out_valid_q;
	out_item_t                out_data_q, out_d;

	logic [95:0]  full_mant;
	logic [4:0]   scale_in;
	logic         accept;
	logic         advance;      // output register can take a character
	logic         emit;
	logic         digit_emit;
	logic [5:0]   pos_ext;
	logic [5:0]   scale_ext;
	cell_mode_t   mode;
	digit_t       top_digit;

	assign accept    = number.valid && number.ready;
	assign advance   = !out_valid_q || text.ready;
	assign full_mant = {number.payload.mantissa_high, number.payload.mantissa_low};
	assign scale_in  = (number.payload.scale > SCALE_MAX) ? SCALE_MAX : number.payload.scale;

	assign number.ready = (state_q == ST_IDLE);
	assign text.valid   = out_valid_q;
	assign text.payload = out_data_q;

	// the digit at position scale+1 is always sent: it is the lone '0'
	// of an empty integer part, or the lowest integer digit
	assign pos_ext    = 6'(pos_q);
	assign scale_ext  = {1'b0, scale_q};
	assign digit_emit = started_q || (top_digit != '0) || (pos_ext <= scale_ext + 6'd1);

	d2a_chain #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode),
		.bit_in    (mant_q[MANTISSA_BITS-1]),
		.top_digit (top_digit)
	);

	always_comb begin
		state_d           = state_q;
		mode              = CELL_HOLD;
		emit              = 1'b0;
		out_d.char_out    = ASCII_ZERO + {4'd0, top_digit};
		out_d.last_char   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mode    = CELL_CLEAR;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				mode = CELL_DABBLE;
				if (cnt_q == LAST_SHIFT) begin
					state_d = neg_q ? ST_SIGN : ST_DIGIT;
				end
			end
			ST_SIGN: begin
				if (advance) begin
					emit           = 1'b1;
					out_d.char_out = ASCII_MINUS;
					state_d        = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (advance) begin
					mode            = CELL_SHIFT;
					emit            = digit_emit;
					out_d.last_char = (pos_q == POS_ONE);
					// point goes right after the lowest integer digit
					if (digit_emit && (pos_ext == scale_ext + 6'd1) && (scale_q != '0)) begin
						state_d = ST_DOT;
					end else if (pos_q == POS_ONE) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DOT: begin
				if (advance) begin
					emit           = 1'b1;
					out_d.char_out = ASCII_DOT;
					state_d        = ST_DIGIT;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pos_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q     <= '0;
				pos_q     <= POS_TOP;
				started_q <= 1'b0;
			end else if (state_q == ST_CONV) begin
				cnt_q <= cnt_q + 1'b1;
			end else if ((state_q == ST_DIGIT) && advance) begin
				pos_q     <= pos_q - 1'b1;
				started_q <= started_q || digit_emit;
			end
			if (advance) begin
				out_valid_q <= emit;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mant_q  <= full_mant[MANTISSA_BITS-1:0];
			scale_q <= scale_in;
			neg_q   <= number.payload.negative;
		end else if (state_q == ST_CONV) begin
			mant_q <= {mant_q[MANTISSA_BITS-2:0], 1'b0};
		end
		if (advance && emit) begin
			out_data_q <= out_d;
		end
	end

	// an accepted number always starts a fresh conversion
	`D2A_ASSERT_NEXT(a_accept_starts_conv, accept, (state_q == ST_CONV) && (cnt_q == '0))
	// the final character leaves the sequencer back between numbers
	`D2A_ASSERT_NEXT(a_last_is_idle, advance && emit && out_d.last_char, state_q == ST_IDLE)
	// printing never runs past the lowest digit
	`D2A_ASSERT_SAME(a_pos_range, state_q == ST_DIGIT, (pos_q != '0) && (pos_q <= POS_TOP))
	// clamped scale while a number is in flight
	`D2A_ASSERT_SAME(a_scale_clamped, state_q != ST_IDLE, scale_q <= SCALE_MAX)
	// the shift counter ends the pass exactly at the last mantissa bit
	`D2A_ASSERT_SAME(a_conv_count, state_q == ST_CONV, cnt_q <= LAST_SHIFT)

endmodule

`default_nettype wire

### tb/decimal96_to_ascii_top_test.sv
// -----------------------------------------------------------------------------
// decimal96_to_ascii_top_test: self-checking bench for the decimal printer
// Drives 96-bit decimal numbers into number, predicts the text for each one
// by repeated division by ten, and checks every character beat on text,
// including the last_char flag, while both sides idle and stall at random.
// -----------------------------------------------------------------------------
module decimal96_to_ascii_top_test;

	import d2a_pkg::*;

	// run shape
	localparam int RANDOM_ITEMS = 440;
	localparam int IDLE_PCT     = 12;      // idle beats per hundred on each side
	localparam int CALM_FIRST   = 150;     // first random item with no idling at all
	localparam int CALM_LAST    = 229;
	localparam int DRAIN_AT     = 320;     // sender waits for all text here
	localparam int HOLD_AT      = 3000;    // chars seen before the long hold-off
	localparam int HOLD_CYCLES  = 600;
	localparam int TAIL_CYCLES  = 200;     // a bit more than one full number
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int LAST_SCALE   = MAX_DIGITS_DEF - 1;

	// ---------------------------------------------------------------------
	// text predictor: turns an accepted number into its expected characters
	// ---------------------------------------------------------------------
	class decimal_text_predictor;
		out_item_t   pending_chars[$];
		int unsigned mismatches;
		int          chars_left;

		function new();
			mismatches = 0;
			chars_left = 0;
		endfunction

		// queue one character, flagging the final one of the string
		function void push_char(logic [7:0] ch);
			out_item_t c;
			chars_left--;
			c.char_out  = ch;
			c.last_char = (chars_left == 0);
			pending_chars.push_back(c);
		endfunction

		function void note_number(in_item_t num);
			logic [95:0] rest;
			digit_t      digits [MAX_DIGITS_DEF];
			int          frac;
			int          top;
			rest = {num.mantissa_high, num.mantissa_low};
			frac = (num.scale > LAST_SCALE) ? LAST_SCALE : int'(num.scale);
			// top = count of significant digits, at least one
			top = 1;
			for (int k = 0; k < MAX_DIGITS_DEF; k++) begin
				digits[k] = digit_t'(rest % 96'd10);
				rest      = rest / 96'd10;
				if (digits[k] != 0)
					top = k + 1;
			end
			chars_left = int'(num.negative) + ((top > frac) ? top - frac : 1)
				+ ((frac > 0) ? frac + 1 : 0);
			// minus zero still gets its sign
			if (num.negative)
				push_char(ASCII_MINUS);
			// empty integer part prints as one zero
			if (top > frac) begin
				for (int k = top - 1; k >= frac; k--)
					push_char(ASCII_ZERO + digits[k]);
			end else begin
				push_char(ASCII_ZERO);
			end
			// fraction keeps its leading zeros
			if (frac > 0) begin
				push_char(ASCII_DOT);
				for (int k = frac - 1; k >= 0; k--)
					push_char(ASCII_ZERO + digits[k]);
			end
		endfunction

		function void check_char(out_item_t got);
			out_item_t want;
			if (pending_chars.size() == 0) begin
				$error("char_out unexpected: expected none, got %h", got.char_out);
				mismatches++;
			end else begin
				want = pending_chars.pop_front();
				if (got.char_out !== want.char_out) begin
					$error("char_out mismatch: expected %h, got %h",
						want.char_out, got.char_out);
					mismatches++;
				end
				if (got.last_char !== want.last_char) begin
					$error("last_char mismatch: expected %b, got %b",
						want.last_char, got.last_char);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	d2a_if #(.payload_t(in_item_t))  number_ch ();
	d2a_if #(.payload_t(out_item_t)) text_ch ();

	decimal96_to_ascii_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number_ch),
		.text   (text_ch)
	);

	decimal_text_predictor printer;

	bit          calm;          // both sides stop idling while set
	bit          held_off;      // long receiver hold-off already done
	int          hold_left;
	int unsigned chars_seen;
	int unsigned cycle_count;

	// free-running clock, period 8
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// receiver: ready changes on the falling edge only
	// ---------------------------------------------------------------------
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				text_ch.ready <= 1'b0;
			end else if (!held_off && chars_seen >= HOLD_AT) begin
				// long hold-off: the printer fills up and number stalls
				held_off  = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				text_ch.ready <= 1'b0;
			end else begin
				text_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// text beats checked at the rising edge
	always @(posedge clk) begin
		if (arst_n && text_ch.valid && text_ch.ready) begin
			printer.check_char(text_ch.payload);
			chars_seen++;
		end
	end

	// ---------------------------------------------------------------------
	// sender
	// ---------------------------------------------------------------------

	// offer one number, with an occasional idle gap ahead of it
	task automatic send_number(input logic [95:0] mant, input int frac, input bit neg);
		in_item_t num;
		num.mantissa_low  = mant[63:0];
		num.mantissa_high = mant[95:64];
		num.scale         = frac[4:0];
		num.negative      = neg;
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			repeat ($urandom_range(4, 1)) begin
				@(negedge clk);
				number_ch.valid <= 1'b0;
			end
		end
		@(negedge clk);
		number_ch.valid   <= 1'b1;
		number_ch.payload <= num;
		do
			@(posedge clk);
		while (!number_ch.ready);
		printer.note_number(num);
	endtask

	function automatic logic [95:0] ten_to(input int k);
		logic [95:0] p;
		p = 96'd1;
		repeat (k)
			p = p * 96'd10;
		return p;
	endfunction

	// mostly random magnitudes, sometimes right at a digit boundary
	function automatic logic [95:0] random_mantissa();
		logic [95:0] m;
		int          width;
		if ($urandom_range(7) == 0) begin
			m = ten_to($urandom_range(28));
			if ($urandom_range(1))
				m = m - 96'd1;
		end else begin
			width = $urandom_range(96);
			m     = {$urandom, $urandom, $urandom};
			if (width < 96)
				m = m & ((96'd1 << width) - 96'd1);
		end
		return m;
	endfunction

	// scale mostly legal, a few beyond the clamp point
	function automatic int random_scale();
		if ($urandom_range(99) < 6)
			return $urandom_range(31, MAX_DIGITS_DEF);
		return $urandom_range(LAST_SCALE);
	endfunction

	initial begin
		printer           = new();
		arst_n            = 1'b0;
		number_ch.valid   = 1'b0;
		number_ch.payload = '0;
		text_ch.ready     = 1'b0;
		calm              = 1'b0;
		held_off          = 1'b0;
		hold_left         = 0;
		chars_seen        = 0;
		cycle_count       = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed: zeros, extremes, empty integer part, clamped scales
		send_number(96'd0, 0, 1'b0);
		send_number(96'd0, 0, 1'b1);              // minus zero
		send_number(96'd0, LAST_SCALE, 1'b0);     // 0. and 28 zeros
		send_number(96'd0, 5, 1'b1);
		send_number({96{1'b1}}, 0, 1'b0);         // all 29 digits
		send_number({96{1'b1}}, LAST_SCALE, 1'b1);// longest string
		send_number(96'd1, LAST_SCALE, 1'b0);     // deep zero padding
		send_number(96'd5, 2, 1'b0);              // 0.05
		send_number(96'd99, 2, 1'b1);             // digits equal scale
		send_number(96'd100, 2, 1'b0);            // one digit past scale
		send_number(96'd123456789, 3, 1'b0);
		send_number(ten_to(28), LAST_SCALE, 1'b0);
		send_number(ten_to(28) - 96'd1, LAST_SCALE, 1'b1);
		send_number({32'd0, {64{1'b1}}}, 7, 1'b0);
		send_number({{32{1'b1}}, 64'd0}, 13, 1'b1);
		send_number(96'd7, 29, 1'b0);             // clamped scales
		send_number(96'd7, 30, 1'b1);
		send_number(96'd12345, 31, 1'b0);
		send_number(96'd9, 1, 1'b0);
		send_number(ten_to(19), 0, 1'b1);

		// random part with a calm stretch and one full drain
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= CALM_FIRST && n <= CALM_LAST);
			if (n == DRAIN_AT) begin
				@(negedge clk);
				number_ch.valid <= 1'b0;
				while (printer.pending_chars.size() != 0)
					@(posedge clk);
			end
			send_number(random_mantissa(), random_scale(), 1'($urandom_range(1)));
		end
		calm = 1'b0;
		@(negedge clk);
		number_ch.valid <= 1'b0;

		// let the last text out, then watch for stray beats
		while (printer.pending_chars.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (printer.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
